/* hw/rtl/udpdmx_pkg.sv */
// Package for the UDP endpoint demultiplex table.
// Opcodes, status codes, entry modes and the shared command and result types.
// No dependencies.
package udpdmx_pkg;

    localparam int SLOTS_DEF       = 8;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int SLOT_W          = 4;
    localparam int CMDQ_DEPTH      = 2;

    localparam logic [2:0] OP_REGISTER = 3'd0;
    localparam logic [2:0] OP_PACKET   = 3'd1;
    localparam logic [2:0] OP_RECEIVE  = 3'd2;
    localparam logic [2:0] OP_CANCEL   = 3'd3;
    localparam logic [2:0] OP_RELEASE  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ERROR   = 2'd1;
    localparam logic [1:0] ST_WAITING = 2'd2;
    localparam logic [1:0] ST_DISCARD = 2'd3;

    localparam logic [1:0] MODE_FREE = 2'd0;
    localparam logic [1:0] MODE_USED = 2'd1;
    localparam logic [1:0] MODE_WAIT = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  slot;
        logic [31:0] remote_ip;
        logic [15:0] remote_port;
        logic [15:0] local_port;
        logic [15:0] buffer_handle;
        logic [15:0] udp_length;
        logic [15:0] capacity;
        logic [7:0]  waiter_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_out;
        logic [15:0] handle_out;
        logic        free_handle;
        logic        wake;
        logic [7:0]  waiter_out;
        logic [31:0] sender_ip;
        logic [15:0] sender_port;
        logic [15:0] copy_length;
        logic        last;
    } result_t;

endpackage

/* hw/rtl/udp_endpoint_demux_queues.sv */
// UDP endpoint demultiplex table with per-endpoint packet handle rings.
// Top level: front command queue and back-end engine. Depends on udpdmx_pkg.
//
// Input channel: push/full with opcode, slot, addressing, handle, length,
// capacity and waiter fields. A transfer happens when push is high and full
// is low. The command queue holds two items ahead of the engine.
// Result channel: empty/pop; the oldest result is on the ports while empty is
// low, a transfer happens when pop is high and empty is low. last marks the
// final result of a command.
// Sequence: register, packet, cancel and simple cases go from idle through
// the execute state to the result register; a receive that dequeues also
// passes the ring read and output states. Release gives one result per queued
// handle, each through the read and output states, then its final result. The
// engine takes a new command only when idle, so commands run one at a time.
// Reset clears the table to all free and the rings to empty at once.
// When the receiver stalls, the result register holds and the engine waits;
// the command queue keeps taking items until it fills.
module udp_endpoint_demux_queues
#(
    parameter int SLOTS       = udpdmx_pkg::SLOTS_DEF,
    parameter int QUEUE_DEPTH = udpdmx_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  opcode,
    input  logic [3:0]  slot,
    input  logic [31:0] remote_ip,
    input  logic [15:0] remote_port,
    input  logic [15:0] local_port,
    input  logic [15:0] buffer_handle,
    input  logic [15:0] udp_length,
    input  logic [15:0] capacity,
    input  logic [7:0]  waiter_id,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [3:0]  slot_out,
    output logic [15:0] handle_out,
    output logic        free_handle,
    output logic        wake,
    output logic [7:0]  waiter_out,
    output logic [31:0] sender_ip,
    output logic [15:0] sender_port,
    output logic [15:0] copy_length,
    output logic        last
);
    udpdmx_pkg::cmd_t    in_cmd, q_cmd;
    udpdmx_pkg::result_t r;
    logic q_empty, take, rv;

    assign in_cmd = '{opcode, slot, remote_ip, remote_port, local_port,
                      buffer_handle, udp_length, capacity, waiter_id};

    udpdmx_cmd_fifo u_fifo
    (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(in_cmd), .full(full),
        .pop(take), .pop_data(q_cmd), .empty(q_empty)
    );

    udpdmx_engine #(.SLOTS(SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_engine
    (
        .clk(clk), .rst_n(rst_n), .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_take(take),
        .res_valid(rv), .res(r), .res_pop(pop)
    );

    assign empty       = !rv;
    assign status      = r.status;
    assign slot_out    = r.slot_out;
    assign handle_out  = r.handle_out;
    assign free_handle = r.free_handle;
    assign wake        = r.wake;
    assign waiter_out  = r.waiter_out;
    assign sender_ip   = r.sender_ip;
    assign sender_port = r.sender_port;
    assign copy_length = r.copy_length;
    assign last        = r.last;
endmodule

/* hw/rtl/udpdmx_cmd_fifo.sv */
// Command queue between the front decode and the back-end engine.
// Depends on udpdmx_pkg.
module udpdmx_cmd_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  udpdmx_pkg::cmd_t   push_data,
    output logic               full,
    input  logic               pop,
    output udpdmx_pkg::cmd_t   pop_data,
    output logic               empty
);
    udpdmx_pkg::cmd_t mem_reg [udpdmx_pkg::CMDQ_DEPTH];
    logic [$clog2(udpdmx_pkg::CMDQ_DEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(udpdmx_pkg::CMDQ_DEPTH):0]   cnt_reg;

    assign full     = (cnt_reg == ($clog2(udpdmx_pkg::CMDQ_DEPTH)+1)'(udpdmx_pkg::CMDQ_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + ((push && !full) ? 1'b1 : 1'b0) - ((pop && !empty) ? 1'b1 : 1'b0);
        end
    end
endmodule

/* hw/rtl/udpdmx_engine.sv */
// Back-end engine: endpoint table, per-slot rings and result register.
// Depends on udpdmx_pkg.
module udpdmx_engine
#(
    parameter int SLOTS       = udpdmx_pkg::SLOTS_DEF,
    parameter int QUEUE_DEPTH = udpdmx_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  udpdmx_pkg::cmd_t    cmd,
    output logic                cmd_take,
    output logic                res_valid,
    output udpdmx_pkg::result_t res,
    input  logic                res_pop
);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MW = $clog2(SLOTS * QUEUE_DEPTH);
    localparam int AW = (MW > 0) ? MW : 1;

    typedef enum logic [3:0]
    {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    udpdmx_pkg::cmd_t c_reg;

    logic [1:0]  mode_reg  [SLOTS];
    logic [15:0] lport_reg [SLOTS];
    logic [15:0] rport_reg [SLOTS];
    logic [31:0] rip_reg   [SLOTS];
    logic [7:0]  wait_reg  [SLOTS];
    logic [CW-1:0] count_reg [SLOTS];
    logic [QW-1:0] head_reg  [SLOTS];
    logic [QW-1:0] tail_reg  [SLOTS];

    logic [79:0] qmem [SLOTS * QUEUE_DEPTH];
    logic [79:0] rd_reg;

    udpdmx_pkg::result_t res_reg;
    logic                resv_reg;
    logic                rel_reg;
    logic [SW-1:0]       tsl_reg;

    logic [SLOTS-1:0] dup, fre, hit;
    logic [SW-1:0] fre_i, hit_i;
    logic          any_dup, any_fre, any_hit;
    logic [SW-1:0] sl;
    logic          sl_ok;

    function automatic logic [AW-1:0] addr(input logic [SW-1:0] s, input logic [QW-1:0] p);
        logic [31:0] a;
        a = 32'(s) * 32'(QUEUE_DEPTH) + 32'(p);
        return a[AW-1:0];
    endfunction

    function automatic logic [QW-1:0] nxt(input logic [QW-1:0] p);
        return (32'(p) + 1 >= QUEUE_DEPTH) ? '0 : QW'(32'(p) + 1);
    endfunction

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            dup[i] = mode_reg[i] != udpdmx_pkg::MODE_FREE && rport_reg[i] == c_reg.remote_port
                     && lport_reg[i] == c_reg.local_port && rip_reg[i] == c_reg.remote_ip;
            fre[i] = mode_reg[i] == udpdmx_pkg::MODE_FREE;
            hit[i] = mode_reg[i] != udpdmx_pkg::MODE_FREE && lport_reg[i] == c_reg.local_port
                     && (rport_reg[i] == '0 || rport_reg[i] == c_reg.remote_port)
                     && (rip_reg[i] == '0 || rip_reg[i] == c_reg.remote_ip)
                     && count_reg[i] != CW'(QUEUE_DEPTH);
        end
        fre_i = '0;
        hit_i = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (fre[i])
            begin
                fre_i = SW'(i);
            end
            if (hit[i])
            begin
                hit_i = SW'(i);
            end
        end
        any_dup = |dup;
        any_fre = |fre;
        any_hit = |hit;
        sl    = c_reg.slot[SW-1:0];
        sl_ok = 32'(c_reg.slot) < SLOTS;
    end

    assign cmd_take  = (state_reg == S_IDLE) && cmd_valid;
    assign res_valid = resv_reg;
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC && c_reg.opcode == udpdmx_pkg::OP_PACKET && any_hit)
        begin
            qmem[addr(hit_i, tail_reg[hit_i])] <= {c_reg.buffer_handle, c_reg.udp_length,
                                                   c_reg.remote_ip, c_reg.remote_port};
        end
        rd_reg <= qmem[addr(sl, head_reg[sl])];
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            c_reg <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            resv_reg  <= 1'b0;
            rel_reg   <= 1'b0;
            tsl_reg   <= '0;
            res_reg   <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                mode_reg[i]  <= udpdmx_pkg::MODE_FREE;
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                lport_reg[i] <= '0;
                rport_reg[i] <= '0;
                rip_reg[i]   <= '0;
                wait_reg[i]  <= '0;
            end
        end
        else
        begin
            if (res_pop && resv_reg)
            begin
                resv_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (!resv_reg || res_pop)
                    begin
                        res_reg          <= '0;
                        res_reg.last     <= 1'b1;
                        res_reg.status   <= udpdmx_pkg::ST_ERROR;
                        resv_reg         <= 1'b1;
                        state_reg        <= S_IDLE;
                        case (c_reg.opcode)
                            udpdmx_pkg::OP_REGISTER:
                            begin
                                if (!any_dup && any_fre)
                                begin
                                    lport_reg[fre_i] <= c_reg.local_port;
                                    rport_reg[fre_i] <= c_reg.remote_port;
                                    rip_reg[fre_i]   <= c_reg.remote_ip;
                                    wait_reg[fre_i]  <= 8'hFF;
                                    count_reg[fre_i] <= '0;
                                    head_reg[fre_i]  <= '0;
                                    tail_reg[fre_i]  <= '0;
                                    mode_reg[fre_i]  <= udpdmx_pkg::MODE_USED;
                                    res_reg.status   <= udpdmx_pkg::ST_OK;
                                    res_reg.slot_out <= 4'(fre_i);
                                end
                            end
                            udpdmx_pkg::OP_PACKET:
                            begin
                                if (any_hit)
                                begin
                                    tail_reg[hit_i]  <= nxt(tail_reg[hit_i]);
                                    count_reg[hit_i] <= count_reg[hit_i] + 1'b1;
                                    res_reg.status   <= udpdmx_pkg::ST_OK;
                                    res_reg.slot_out <= 4'(hit_i);
                                    if (mode_reg[hit_i] == udpdmx_pkg::MODE_WAIT)
                                    begin
                                        mode_reg[hit_i]    <= udpdmx_pkg::MODE_USED;
                                        res_reg.wake       <= 1'b1;
                                        res_reg.waiter_out <= wait_reg[hit_i];
                                    end
                                end
                                else
                                begin
                                    res_reg.status      <= udpdmx_pkg::ST_DISCARD;
                                    res_reg.handle_out  <= c_reg.buffer_handle;
                                    res_reg.free_handle <= 1'b1;
                                end
                            end
                            udpdmx_pkg::OP_RECEIVE:
                            begin
                                if (sl_ok && mode_reg[sl] == udpdmx_pkg::MODE_USED)
                                begin
                                    if (count_reg[sl] == '0)
                                    begin
                                        mode_reg[sl]   <= udpdmx_pkg::MODE_WAIT;
                                        wait_reg[sl]   <= c_reg.waiter_id;
                                        res_reg.status <= udpdmx_pkg::ST_WAITING;
                                    end
                                    else
                                    begin
                                        resv_reg  <= resv_reg && !res_pop;
                                        rel_reg   <= 1'b0;
                                        state_reg <= S_READ;
                                    end
                                end
                            end
                            udpdmx_pkg::OP_CANCEL:
                            begin
                                if (sl_ok && mode_reg[sl] == udpdmx_pkg::MODE_WAIT)
                                begin
                                    mode_reg[sl]   <= udpdmx_pkg::MODE_USED;
                                    res_reg.status <= udpdmx_pkg::ST_OK;
                                end
                            end
                            udpdmx_pkg::OP_RELEASE:
                            begin
                                if (sl_ok && mode_reg[sl] != udpdmx_pkg::MODE_FREE)
                                begin
                                    if (count_reg[sl] == '0)
                                    begin
                                        mode_reg[sl]   <= udpdmx_pkg::MODE_FREE;
                                        res_reg.status <= udpdmx_pkg::ST_OK;
                                    end
                                    else
                                    begin
                                        resv_reg  <= resv_reg && !res_pop;
                                        rel_reg   <= 1'b1;
                                        state_reg <= S_READ;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        tsl_reg <= sl;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!resv_reg || res_pop)
                    begin
                        res_reg             <= '0;
                        res_reg.handle_out  <= rd_reg[79:64];
                        res_reg.free_handle <= 1'b1;
                        resv_reg            <= 1'b1;
                        head_reg[tsl_reg]   <= nxt(head_reg[tsl_reg]);
                        count_reg[tsl_reg]  <= count_reg[tsl_reg] - 1'b1;
                        if (rel_reg)
                        begin
                            state_reg <= S_READ;
                            if (count_reg[tsl_reg] == CW'(1))
                            begin
                                state_reg <= S_EXEC;
                            end
                        end
                        else
                        begin
                            res_reg.last        <= 1'b1;
                            res_reg.sender_ip   <= rd_reg[47:16];
                            res_reg.sender_port <= rd_reg[15:0];
                            res_reg.copy_length <= (rd_reg[63:48] < 16'd8) ? 16'd0 :
                                (c_reg.capacity < rd_reg[63:48] - 16'd8) ? c_reg.capacity :
                                rd_reg[63:48] - 16'd8;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

/* dv/tb_udp_endpoint_demux_queues.sv */
`timescale 1ns / 1ps
// Testbench for udp_endpoint_demux_queues: directed and random command streams with
// bursty push and stalling pop, checked against an in-bench endpoint table predictor.
// Depends on udpdmx_pkg and the udp_endpoint_demux_queues RTL.
module tb_udp_endpoint_demux_queues;

    localparam int NSLOT = udpdmx_pkg::SLOTS_DEF;
    localparam int DEPTH = udpdmx_pkg::QUEUE_DEPTH_DEF;
    localparam int IDLE_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [2:0]  opcode = '0;
    logic [3:0]  slot = '0;
    logic [31:0] remote_ip = '0;
    logic [15:0] remote_port = '0;
    logic [15:0] local_port = '0;
    logic [15:0] buffer_handle = '0;
    logic [15:0] udp_length = '0;
    logic [15:0] capacity = '0;
    logic [7:0]  waiter_id = '0;
    logic        full, empty, free_handle, wake, last;
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic [15:0] handle_out, sender_port, copy_length;
    logic [7:0]  waiter_out;
    logic [31:0] sender_ip;

    udp_endpoint_demux_queues DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .opcode(opcode), .slot(slot),
        .remote_ip(remote_ip), .remote_port(remote_port), .local_port(local_port),
        .buffer_handle(buffer_handle), .udp_length(udp_length), .capacity(capacity),
        .waiter_id(waiter_id), .empty(empty), .pop(pop), .status(status),
        .slot_out(slot_out), .handle_out(handle_out), .free_handle(free_handle),
        .wake(wake), .waiter_out(waiter_out), .sender_ip(sender_ip),
        .sender_port(sender_port), .copy_length(copy_length), .last(last)
    );

    // endpoint table mirror
    logic [1:0]  ep_mode [NSLOT];
    logic [15:0] ep_lport [NSLOT];
    logic [15:0] ep_rport [NSLOT];
    logic [31:0] ep_rip [NSLOT];
    logic [7:0]  ep_waiter [NSLOT];
    int          ring_cnt [NSLOT];
    int          ring_head [NSLOT];
    int          ring_tail [NSLOT];
    logic [15:0] ring_handle [NSLOT][DEPTH];
    logic [15:0] ring_len [NSLOT][DEPTH];
    logic [31:0] ring_ip [NSLOT][DEPTH];
    logic [15:0] ring_port [NSLOT][DEPTH];

    udpdmx_pkg::cmd_t    pending_cmds[$];
    udpdmx_pkg::result_t expected_results[$];
    udpdmx_pkg::cmd_t    cur_cmd;
    int      errors = 0;
    int      n_cmds = 0;
    int      n_results = 0;
    int      n_wakes = 0;
    int      n_discards = 0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      idle_cycles = 0;
    int      cyc = 0;
    logic [6:0] stall_pat = 7'b1011001;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic udpdmx_pkg::result_t blank_result(logic [1:0] st);
        udpdmx_pkg::result_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void predict_endpoint(udpdmx_pkg::cmd_t c);
        udpdmx_pkg::result_t r;
        int i;
        int h;
        int cl;
        bit done;
        done = 0;
        r = blank_result(udpdmx_pkg::ST_ERROR);
        case (c.opcode)
            udpdmx_pkg::OP_REGISTER:
            begin
                for (i = 0; i < NSLOT; i++)
                    if (!done && ep_mode[i] != udpdmx_pkg::MODE_FREE &&
                        ep_rport[i] == c.remote_port &&
                        ep_lport[i] == c.local_port && ep_rip[i] == c.remote_ip)
                        done = 1;
                for (i = 0; i < NSLOT; i++)
                    if (!done && ep_mode[i] == udpdmx_pkg::MODE_FREE)
                    begin
                        ep_lport[i] = c.local_port;
                        ep_rport[i] = c.remote_port;
                        ep_rip[i] = c.remote_ip;
                        ep_waiter[i] = 8'hFF;
                        ring_cnt[i] = 0;
                        ring_head[i] = 0;
                        ring_tail[i] = 0;
                        ep_mode[i] = udpdmx_pkg::MODE_USED;
                        r.status = udpdmx_pkg::ST_OK;
                        r.slot_out = 4'(i);
                        done = 1;
                    end
                expected_results.push_back(r);
            end
            udpdmx_pkg::OP_PACKET:
            begin
                for (i = 0; i < NSLOT; i++)
                    if (!done && ep_mode[i] != udpdmx_pkg::MODE_FREE &&
                        c.local_port == ep_lport[i] &&
                        (ep_rport[i] == 0 || c.remote_port == ep_rport[i]) &&
                        (ep_rip[i] == 0 || c.remote_ip == ep_rip[i]) && ring_cnt[i] < DEPTH)
                    begin
                        h = ring_tail[i];
                        ring_handle[i][h] = c.buffer_handle;
                        ring_len[i][h] = c.udp_length;
                        ring_ip[i][h] = c.remote_ip;
                        ring_port[i][h] = c.remote_port;
                        ring_tail[i] = (h + 1) % DEPTH;
                        ring_cnt[i]++;
                        r.status = udpdmx_pkg::ST_OK;
                        r.slot_out = 4'(i);
                        if (ep_mode[i] == udpdmx_pkg::MODE_WAIT)
                        begin
                            ep_mode[i] = udpdmx_pkg::MODE_USED;
                            r.wake = 1'b1;
                            r.waiter_out = ep_waiter[i];
                        end
                        done = 1;
                    end
                if (!done)
                begin
                    r.status = udpdmx_pkg::ST_DISCARD;
                    r.handle_out = c.buffer_handle;
                    r.free_handle = 1'b1;
                end
                expected_results.push_back(r);
            end
            udpdmx_pkg::OP_RECEIVE:
            begin
                if (c.slot < NSLOT && ep_mode[c.slot] == udpdmx_pkg::MODE_USED)
                begin
                    if (ring_cnt[c.slot] == 0)
                    begin
                        ep_mode[c.slot] = udpdmx_pkg::MODE_WAIT;
                        ep_waiter[c.slot] = c.waiter_id;
                        r.status = udpdmx_pkg::ST_WAITING;
                    end
                    else
                    begin
                        h = ring_head[c.slot];
                        ring_head[c.slot] = (h + 1) % DEPTH;
                        ring_cnt[c.slot]--;
                        cl = (ring_len[c.slot][h] < 8) ? 0 : ring_len[c.slot][h] - 8;
                        if (c.capacity < cl)
                            cl = c.capacity;
                        r.status = udpdmx_pkg::ST_OK;
                        r.handle_out = ring_handle[c.slot][h];
                        r.free_handle = 1'b1;
                        r.sender_ip = ring_ip[c.slot][h];
                        r.sender_port = ring_port[c.slot][h];
                        r.copy_length = 16'(cl);
                    end
                end
                expected_results.push_back(r);
            end
            udpdmx_pkg::OP_CANCEL:
            begin
                if (c.slot < NSLOT && ep_mode[c.slot] == udpdmx_pkg::MODE_WAIT)
                begin
                    ep_mode[c.slot] = udpdmx_pkg::MODE_USED;
                    r.status = udpdmx_pkg::ST_OK;
                end
                expected_results.push_back(r);
            end
            udpdmx_pkg::OP_RELEASE:
            begin
                if (c.slot < NSLOT && ep_mode[c.slot] != udpdmx_pkg::MODE_FREE)
                begin
                    while (ring_cnt[c.slot] > 0)
                    begin
                        r = '0;
                        r.handle_out = ring_handle[c.slot][ring_head[c.slot]];
                        r.free_handle = 1'b1;
                        expected_results.push_back(r);
                        ring_head[c.slot] = (ring_head[c.slot] + 1) % DEPTH;
                        ring_cnt[c.slot]--;
                    end
                    ep_mode[c.slot] = udpdmx_pkg::MODE_FREE;
                    r = blank_result(udpdmx_pkg::ST_OK);
                end
                expected_results.push_back(r);
            end
            default: expected_results.push_back(r);
        endcase
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] %s: got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic udpdmx_pkg::cmd_t mk(logic [2:0] op, logic [3:0] sl, logic [31:0] ip,
                                            logic [15:0] rp, logic [15:0] lp,
                                            logic [15:0] hd, logic [15:0] ln,
                                            logic [15:0] cp, logic [7:0] wd);
        udpdmx_pkg::cmd_t c;
        c.opcode = op; c.slot = sl; c.remote_ip = ip; c.remote_port = rp;
        c.local_port = lp; c.buffer_handle = hd; c.udp_length = ln;
        c.capacity = cp; c.waiter_id = wd;
        return c;
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 5))
            0: return 16'd7;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h1234;
            default: return $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'd53;
        endcase
    endfunction

    function automatic logic [31:0] pick_ip(bit allow_any);
        case ($urandom_range(0, 4))
            0: return allow_any ? 32'h0 : 32'hFFFF_FFFF;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0A00_0001;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_rport(bit allow_any);
        case ($urandom_range(0, 3))
            0: return allow_any ? 16'h0 : 16'hFFFF;
            1: return 16'd4000;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic udpdmx_pkg::cmd_t random_cmd();
        int w;
        udpdmx_pkg::cmd_t c;
        w = $urandom_range(0, 99);
        c = mk(udpdmx_pkg::OP_PACKET,
               4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 7)),
               pick_ip(0), pick_rport(0), pick_port(), 16'($urandom),
               16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : $urandom),
               16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 64)),
               8'($urandom));
        if (w < 15)
        begin
            c.opcode = udpdmx_pkg::OP_REGISTER;
            c.remote_ip = pick_ip(1);
            c.remote_port = pick_rport(1);
        end
        else if (w < 55)
            c.opcode = udpdmx_pkg::OP_PACKET;
        else if (w < 80)
            c.opcode = udpdmx_pkg::OP_RECEIVE;
        else if (w < 87)
            c.opcode = udpdmx_pkg::OP_CANCEL;
        else if (w < 95)
            c.opcode = udpdmx_pkg::OP_RELEASE;
        else
            c.opcode = 3'($urandom_range(5, 7));
        return c;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        bit go;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            go = push;
            if (push && !full)
            begin
                predict_endpoint(cur_cmd);
                n_cmds++;
                go = 0;
            end
            if (!go)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_cmds.size() > 0)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    opcode <= cur_cmd.opcode;
                    slot <= cur_cmd.slot;
                    remote_ip <= cur_cmd.remote_ip;
                    remote_port <= cur_cmd.remote_port;
                    local_port <= cur_cmd.local_port;
                    buffer_handle <= cur_cmd.buffer_handle;
                    udp_length <= cur_cmd.udp_length;
                    capacity <= cur_cmd.capacity;
                    waiter_id <= cur_cmd.waiter_id;
                    go = 1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 9);
                    end
                end
            end
            push <= go;
        end
    end

    // monitor, pop stall pattern and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        udpdmx_pkg::result_t exp_r;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            cyc++;
            if ((pop && !empty) || (push && !full))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (pop && !empty)
            begin
                n_results++;
                if (wake)
                    n_wakes++;
                if (status == udpdmx_pkg::ST_DISCARD)
                    n_discards++;
                if (expected_results.size() == 0)
                    report("unexpected result", 32'(status), 32'd0);
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (status !== exp_r.status)
                        report("status", 32'(status), 32'(exp_r.status));
                    if (slot_out !== exp_r.slot_out)
                        report("slot_out", 32'(slot_out), 32'(exp_r.slot_out));
                    if (handle_out !== exp_r.handle_out)
                        report("handle_out", 32'(handle_out), 32'(exp_r.handle_out));
                    if (free_handle !== exp_r.free_handle)
                        report("free_handle", 32'(free_handle), 32'(exp_r.free_handle));
                    if (wake !== exp_r.wake)
                        report("wake", 32'(wake), 32'(exp_r.wake));
                    if (waiter_out !== exp_r.waiter_out)
                        report("waiter_out", 32'(waiter_out), 32'(exp_r.waiter_out));
                    if (sender_ip !== exp_r.sender_ip)
                        report("sender_ip", sender_ip, exp_r.sender_ip);
                    if (sender_port !== exp_r.sender_port)
                        report("sender_port", 32'(sender_port), 32'(exp_r.sender_port));
                    if (copy_length !== exp_r.copy_length)
                        report("copy_length", 32'(copy_length), 32'(exp_r.copy_length));
                    if (last !== exp_r.last)
                        report("last", 32'(last), 32'(exp_r.last));
                end
            end
            stall_pat = {stall_pat[5:0], stall_pat[6]};
            if (cyc % 600 < 150)
                pop <= 1'b1;
            else if (cyc % 600 < 350)
                pop <= stall_pat[0];
            else
                pop <= $urandom_range(0, 3) != 0;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("udp_endpoint_demux_queues: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < NSLOT; i++)
        begin
            ep_mode[i] = udpdmx_pkg::MODE_FREE;
            ring_cnt[i] = 0;
            ring_head[i] = 0;
            ring_tail[i] = 0;
        end
        // directed
        pending_cmds.push_back(mk(udpdmx_pkg::OP_REGISTER, 0, 32'h0, 16'h0, 16'd7,
                                  0, 0, 0, 0));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_REGISTER, 0, 32'h0, 16'h0, 16'd7,
                                  0, 0, 0, 0));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_RECEIVE, 0, 0, 0, 0, 0, 0, 16'hFFFF, 8'hAB));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_RECEIVE, 0, 0, 0, 0, 0, 0, 16'hFFFF, 8'h54));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_PACKET, 0, 32'hFFFF_FFFF, 16'hFFFF, 16'd7,
                                  16'hFFFF, 16'd5, 0, 0));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_RECEIVE, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_RECEIVE, 0, 0, 0, 0, 0, 0, 0, 8'hFF));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_PACKET, 0, 32'h0A00_0001, 16'd1, 16'd7,
                                  16'h0001, 16'hFFFF, 16'd0, 0));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_PACKET, 0, 32'h0A00_0002, 16'd2, 16'd7,
                                  16'h8000, 16'hFFFF, 16'hFFFF, 0));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_RECEIVE, 0, 0, 0, 0, 0, 0, 16'd0, 0));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_PACKET, 0, 32'h1, 16'd1, 16'hFFFF,
                                  16'h5A5A, 16'd100, 0, 0));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_RECEIVE, 4'd15, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_RELEASE, 4'd8, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(udpdmx_pkg::OP_CANCEL, 4'd3, 0, 0, 0, 0, 0, 0, 0));
        for (i = 0; i < NSLOT + 1; i++)
            pending_cmds.push_back(mk(udpdmx_pkg::OP_REGISTER, 0, 32'hFFFF_FFFF, 16'hFFFF,
                                      16'(100 + i), 0, 0, 0, 0));
        // random: mostly live traffic with some noise mixed in
        for (i = 0; i < 200; i++)
            pending_cmds.push_back(random_cmd());

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_cmds.size() > 0 || push)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("covered %0d commands, %0d results, %0d wakes, %0d discards",
                 n_cmds, n_results, n_wakes, n_discards);
        if (errors == 0)
            $display("udp_endpoint_demux_queues: match");
        else
            $display("udp_endpoint_demux_queues: mismatch");
        $finish;
    end

endmodule
